// File: hw/rtl/fire_heat_simulation_assert.svh
// Assertion macros for the fire heat simulation block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FIRE_HEAT_SIMULATION_ASSERT_SVH
`define FIRE_HEAT_SIMULATION_ASSERT_SVH
`ifndef SYNTHESIS
`define FHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define FHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FHS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define FHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/fhs_pkg.sv
// Shared widths, register indexes and arithmetic constants for the fire heat simulation.
// No dependencies; used by the channel interfaces and the top level.
package fhs_pkg;

  localparam int HEAT_W      = 8;
  localparam int CELL_NUM_W  = 8;
  localparam int DRAW_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int LEN_W       = 9;
  localparam int DIVIDEND_W  = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COOLING_LEVEL = 2'd0,
    REG_SPARK_CHANCE  = 2'd1,
    REG_SEG_LENGTH    = 2'd2
  } cfg_reg_t;

  localparam logic [HEAT_W-1:0] COOLING_RST = 8'd55;
  localparam logic [HEAT_W-1:0] CHANCE_RST  = 8'd120;
  localparam logic [LEN_W-1:0]  SEG_LEN_RST = 9'd60;

  localparam int MIN_LEN     = 2;
  localparam int SPAN_LIMIT  = 7;
  localparam logic [2:0] SPAN_LONG  = 3'd7;
  localparam logic [2:0] SPAN_SHORT = 3'd2;
  localparam int COOL_SCALE  = 10;
  localparam int LIM_OFFSET  = 2;
  localparam int LIM_MAX     = 255;
  localparam logic [HEAT_W-1:0] SPARK_BASE  = 8'd160;
  localparam int SPARK_RANGE = 95;
  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;

endpackage

// File: hw/rtl/fhs_in_if.sv
// Input channel: one word per cell with the cell's random draws.
// Depends on fhs_pkg.
interface fhs_in_if;
  import fhs_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_start;
  logic [DRAW_W-1:0] cool_draw;
  logic [DRAW_W-1:0] spark_roll;
  logic [DRAW_W-1:0] spark_cell_draw;
  logic [DRAW_W-1:0] spark_heat_draw;

  modport source (
    output valid, frame_start, cool_draw, spark_roll, spark_cell_draw, spark_heat_draw,
    input  ready
  );
  modport sink (
    input  valid, frame_start, cool_draw, spark_roll, spark_cell_draw, spark_heat_draw,
    output ready
  );
endinterface

// File: hw/rtl/fhs_out_if.sv
// Output channel: one word per cell with its new heat, index and end-of-frame flag.
// Depends on fhs_pkg.
interface fhs_out_if;
  import fhs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HEAT_W-1:0]     cell_heat;
  logic [CELL_NUM_W-1:0] cell_number;
  logic                  frame_done;

  modport source (
    output valid, cell_heat, cell_number, frame_done,
    input  ready
  );
  modport sink (
    input  valid, cell_heat, cell_number, frame_done,
    output ready
  );
endinterface

// File: hw/rtl/fhs_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on fhs_pkg.
interface fhs_cfg_if;
  import fhs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/fire_heat_simulation.sv
// Fire heat simulation top level: heat store memory, cell pipeline, limit divider, output queue.
// Depends on fhs_pkg, fhs_in_if, fhs_out_if, fhs_cfg_if and fire_heat_simulation_assert.svh.
//
//   channel | dir | words
//   item    | in  | one per cell, frame_start marks cell 0
//   result  | out | one per accepted item, same order
//   cfg     | in  | register writes, always ready
//
// One cell per cycle: the heat store is read at acceptance and written back the next cycle;
// the last write is forwarded when the next read hits the same entry.
// After reset a clearing pass zeroes every entry of the heat store.
// Each write to cooling_level or seg_length reruns the 12-step limit divider.
// A 4-word output queue absorbs stalls; input stalls during clearing, while the divider
// runs, and when queued words plus the word in stage 1 fill all four slots.
`include "fire_heat_simulation_assert.svh"

module fire_heat_simulation #(
  parameter int MAX_CELLS = 256
) (
  input logic      clk,
  input logic      rst,
  fhs_in_if.sink   item,
  fhs_out_if.source result,
  fhs_cfg_if.sink  cfg
);
  import fhs_pkg::*;

  localparam int IDX_W   = $clog2(MAX_CELLS);
  localparam int CMP_W   = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_CELLS);
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int FILL_W  = $clog2(Q_DEPTH + 1);
  localparam int DCNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int D3_W    = 20;

  typedef struct packed {
    logic [HEAT_W-1:0]     heat;
    logic [CELL_NUM_W-1:0] number;
    logic                  done;
  } res_t;

  // configuration and limit divider
  logic [HEAT_W-1:0]     cooling_level;
  logic [HEAT_W-1:0]     spark_chance;
  logic [LEN_W-1:0]      seg_length;
  logic                  div_load;
  logic                  div_busy;
  logic [DCNT_W-1:0]     div_cnt;
  logic [LEN_W-1:0]      dvs;
  logic [LEN_W-1:0]      rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [LEN_W-1:0]      len_q;
  logic                  span7;
  logic [LEN_W-1:0]      len_calc;
  logic [LEN_W:0]        trial;
  logic [LEN_W:0]        trial_diff;
  logic                  trial_ge;
  logic [DIVIDEND_W-1:0] lim_sum;
  logic [HEAT_W-1:0]     lim;
  logic                  cfg_acc;
  logic                  cfg_reload;

  // heat store
  logic [HEAT_W-1:0]     heat_mem [MAX_CELLS];
  logic [HEAT_W-1:0]     mem_q;
  logic                  clr_active;
  logic [IDX_W-1:0]      clr_addr;

  // stage 0
  logic                  in_acc;
  logic [IDX_W-1:0]      cnt;
  logic                  spark_pending;
  logic [2:0]            spark_target;
  logic [HEAT_W-1:0]     spark_amount;
  logic [IDX_W-1:0]      k0;
  logic [2:0]            span;
  logic [10:0]           cell_prod;
  logic [14:0]           heat_prod;
  logic [15:0]           cool_prod;
  logic [2:0]            tgt0;
  logic [HEAT_W-1:0]     amt0;
  logic                  pend0;
  logic                  hit0;
  logic                  last0;

  // stage 1
  logic                  s1_valid;
  logic [IDX_W-1:0]      s1_k;
  logic [HEAT_W-1:0]     s1_cool;
  logic                  s1_hit;
  logic [HEAT_W-1:0]     s1_amt;
  logic                  s1_last;
  logic                  s1_ge2;
  logic [HEAT_W-1:0]     cooled_prev_one;
  logic [HEAT_W-1:0]     cooled_prev_two;
  logic                  fwd_valid;
  logic [IDX_W-1:0]      fwd_addr;
  logic [HEAT_W-1:0]     fwd_data;
  logic [HEAT_W-1:0]     cur;
  logic [HEAT_W-1:0]     cooled;
  logic [LEN_W:0]        sum3;
  logic [D3_W-1:0]       div3_prod;
  logic [HEAT_W-1:0]     div3;
  logic [HEAT_W-1:0]     base;
  logic [HEAT_W:0]       sparked;
  logic [HEAT_W-1:0]     val;

  // output queue
  res_t                  queue [Q_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [FILL_W-1:0]     fill;
  logic                  pop;

  // configuration and divider
  assign cfg.ready  = 1'b1;
  assign cfg_acc    = cfg.valid && cfg.ready;
  assign cfg_reload = cfg_acc &&
                      (cfg_reg_t'(cfg.index) inside {REG_COOLING_LEVEL, REG_SEG_LENGTH});

  always_comb begin
    logic [CMP_W-1:0] seg_cmp;
    logic [CMP_W-1:0] len_cmp;
    seg_cmp = CMP_W'(seg_length);
    if (seg_length < LEN_W'(MIN_LEN)) begin
      len_cmp = CMP_W'(MIN_LEN);
    end else if (seg_cmp > MAX_CMP) begin
      len_cmp = MAX_CMP;
    end else begin
      len_cmp = seg_cmp;
    end
    len_calc = LEN_W'(len_cmp);
  end

  assign trial      = {rem, quo[DIVIDEND_W-1]};
  assign trial_ge   = trial >= {1'b0, dvs};
  assign trial_diff = trial - {1'b0, dvs};
  assign lim_sum    = quo + DIVIDEND_W'(LIM_OFFSET);
  assign lim        = (lim_sum > DIVIDEND_W'(LIM_MAX)) ? HEAT_W'(LIM_MAX) : lim_sum[HEAT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cooling_level <= COOLING_RST;
      spark_chance  <= CHANCE_RST;
      seg_length    <= SEG_LEN_RST;
      div_load      <= 1'b1;
      div_busy      <= 1'b0;
      div_cnt       <= '0;
    end else begin
      div_load <= cfg_reload;
      if (div_load) begin
        dvs      <= len_calc;
        len_q    <= len_calc;
        span7    <= len_calc >= LEN_W'(SPAN_LIMIT);
        rem      <= '0;
        quo      <= DIVIDEND_W'({cooling_level, 3'b000}) + DIVIDEND_W'({cooling_level, 1'b0});
        div_cnt  <= DCNT_W'(DIVIDEND_W);
        div_busy <= 1'b1;
      end else if (div_busy) begin
        rem     <= trial_ge ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
        quo     <= {quo[DIVIDEND_W-2:0], trial_ge};
        div_cnt <= div_cnt - DCNT_W'(1);
        if (div_cnt == DCNT_W'(1)) begin
          div_busy <= 1'b0;
        end
      end
      if (cfg_acc) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_COOLING_LEVEL: begin
            cooling_level <= cfg.data[HEAT_W-1:0];
          end
          REG_SPARK_CHANCE: begin
            spark_chance <= cfg.data[HEAT_W-1:0];
          end
          REG_SEG_LENGTH: begin
            seg_length <= cfg.data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // stage 0: frame bookkeeping, spark latch, cooling amount
  assign item.ready = !clr_active && !div_load && !div_busy &&
                      ((FILL_W + 1)'(fill) + (FILL_W + 1)'(s1_valid) <= (FILL_W + 1)'(Q_DEPTH - 1));
  assign in_acc     = item.valid && item.ready;

  assign k0        = item.frame_start ? '0 : cnt;
  assign span      = span7 ? SPAN_LONG : SPAN_SHORT;
  assign cell_prod = 11'(item.spark_cell_draw) * 11'(span);
  assign heat_prod = 15'(item.spark_heat_draw) * 15'(SPARK_RANGE);
  assign cool_prod = 16'(item.cool_draw) * 16'(lim);
  assign tgt0      = item.frame_start ? cell_prod[10:8] : spark_target;
  assign amt0      = item.frame_start ? SPARK_BASE + {1'b0, heat_prod[14:8]} : spark_amount;
  assign pend0     = item.frame_start ? (item.spark_roll < spark_chance) : spark_pending;
  assign hit0      = pend0 && (k0 == IDX_W'(tgt0));
  assign last0     = (CMP_W'(k0) + CMP_W'(1)) >= CMP_W'(len_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      spark_pending <= 1'b0;
      spark_target  <= '0;
      spark_amount  <= '0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= in_acc;
      if (in_acc) begin
        cnt           <= last0 ? '0 : IDX_W'(k0 + IDX_W'(1));
        spark_pending <= last0 ? 1'b0 : pend0;
        spark_target  <= tgt0;
        spark_amount  <= amt0;
        s1_k          <= k0;
        s1_cool       <= cool_prod[15:8];
        s1_hit        <= hit0;
        s1_amt        <= amt0;
        s1_last       <= last0;
        s1_ge2        <= k0 >= IDX_W'(2);
      end
    end
  end

  // heat store: clearing pass, read at acceptance, write back from stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(MAX_CELLS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q <= heat_mem[k0];
    end
    if (clr_active) begin
      heat_mem[clr_addr] <= '0;
    end else if (s1_valid) begin
      heat_mem[s1_k] <= val;
    end
  end

  // stage 1: cool, diffuse, spark
  assign cur       = (fwd_valid && fwd_addr == s1_k) ? fwd_data : mem_q;
  assign cooled    = (cur > s1_cool) ? cur - s1_cool : '0;
  assign sum3      = {2'b00, cooled_prev_one} + {1'b0, cooled_prev_two, 1'b0};
  assign div3_prod = D3_W'(sum3) * D3_W'(DIV3_MUL);
  assign div3      = div3_prod[DIV3_SHIFT +: HEAT_W];
  assign base      = s1_ge2 ? div3 : cooled;
  assign sparked   = {1'b0, base} + {1'b0, s1_amt};
  assign val       = !s1_hit ? base : (sparked[HEAT_W] ? HEAT_W'(LIM_MAX) : sparked[HEAT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cooled_prev_one <= '0;
      cooled_prev_two <= '0;
      fwd_valid       <= 1'b0;
    end else if (s1_valid) begin
      cooled_prev_two <= cooled_prev_one;
      cooled_prev_one <= cooled;
      fwd_valid       <= 1'b1;
      fwd_addr        <= s1_k;
      fwd_data        <= val;
    end
  end

  // output queue
  assign pop                = result.valid && result.ready;
  assign result.valid       = fill != '0;
  assign result.cell_heat   = queue[rd_ptr].heat;
  assign result.cell_number = queue[rd_ptr].number;
  assign result.frame_done  = queue[rd_ptr].done;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (s1_valid) begin
        queue[wr_ptr] <= '{heat: val, number: CELL_NUM_W'(s1_k), done: s1_last};
        wr_ptr        <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(s1_valid) - FILL_W'(pop);
    end
  end

  `FHS_ASSERT_NOW(a_queue_room, clk, rst, s1_valid, (fill != FILL_W'(Q_DEPTH)) || pop, "output queue overflow")
  `FHS_ASSERT_NEXT(a_last_wraps, clk, rst, in_acc && last0, cnt == '0, "cell count did not wrap")
  `FHS_ASSERT_NEXT(a_result_queued, clk, rst, s1_valid, fill != '0, "finished cell not queued")
  `FHS_ASSERT_NOW(a_no_item_in_setup, clk, rst, clr_active || div_load || div_busy, !in_acc, "item taken during setup")

endmodule
